// ===== hw/rtl/sef_pkg.sv =====
// sef_pkg: shared types and constants of the spring edge force kernel
// no dependencies; imported by spring_edge_force
package sef_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_REST_DIST  = 3'd0,
    REG_REPEL_DIST = 3'd1,
    REG_MIN_STR    = 3'd2,
    REG_MAX_STR    = 3'd3,
    REG_FORCE_LIM  = 3'd4,
    REG_TIME_STEP  = 3'd5
  } cfg_idx_t;

  // fixed point one
  localparam logic [32:0] ONE_Q = 33'd65536;

  // reset values of the configuration registers
  localparam logic [30:0] REST_DIST_RST  = 31'd2097152;
  localparam logic [30:0] REPEL_DIST_RST = 31'd8388608;
  localparam logic [16:0] MIN_STR_RST    = 17'd918;
  localparam logic [16:0] MAX_STR_RST    = 17'd4915;
  localparam logic [30:0] FORCE_LIM_RST  = 31'd212992;
  localparam logic [16:0] TIME_STEP_RST  = 17'd2294;

  // configuration register set
  typedef struct packed {
    logic [30:0] rest_len;
    logic [30:0] repel_len;
    logic [16:0] min_strength;
    logic [16:0] max_strength;
    logic [30:0] force_limit;
    logic [16:0] time_step;
  } cfg_t;

  // side data that travels with an item through the square root
  typedef struct packed {
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;
    logic [16:0]        k;
    logic               neg;
  } sqrt_side_t;

endpackage

// ===== hw/rtl/sef_sqrt.sv =====
// sef_sqrt: pipelined integer square root, one result bit per stage
// standalone; used by spring_edge_force
module sef_sqrt #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 8,
  localparam int ROOT_W = RAD_W / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int T_W   = REM_W + 2;

  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [REM_W-1:0]  rem_nxt[STEPS];
  logic [ROOT_W-1:0] root_r  [STEPS];
  logic [ROOT_W-1:0] root_nxt[STEPS];
  logic [RAD_W-1:0]  rad_r  [STEPS];
  logic [RAD_W-1:0]  rad_nxt[STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic [STEPS-1:0]  vld_r;

  // one trial subtract per stage
  always_comb begin
    logic [REM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [RAD_W-1:0]  rad_src;
    logic [T_W-1:0]    t;
    logic [T_W-1:0]    trial;
    for (int s = 0; s < STEPS; s++) begin
      if (s == 0) begin
        rem_src  = '0;
        root_src = '0;
        rad_src  = in_rad;
      end else begin
        rem_src  = rem_r[s-1];
        root_src = root_r[s-1];
        rad_src  = rad_r[s-1];
      end
      t     = {rem_src, rad_src[RAD_W-1 -: 2]};
      trial = T_W'({root_src, 2'b01});
      if (t >= trial) begin
        rem_nxt[s]  = REM_W'(t - trial);
        root_nxt[s] = {root_src[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = t[REM_W-1:0];
        root_nxt[s] = {root_src[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[s] = rad_src << 2;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < STEPS; s++) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
      rad_r[s]  <= rad_nxt[s];
      side_r[s] <= (s == 0) ? in_side : side_r[s-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

// ===== hw/rtl/sef_div.sv =====
// sef_div: pipelined restoring divider, one quotient bit per stage
// standalone; the upper numerator part must be below the divisor
module sef_div #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 33,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_q,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W-1:0]  rem_r  [Q_W];
  logic [DEN_W-1:0]  rem_nxt[Q_W];
  logic [Q_W-1:0]    lo_r   [Q_W];
  logic [Q_W-1:0]    lo_nxt [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [Q_W-1:0]    q_nxt  [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic [Q_W-1:0]    vld_r;

  // one compare and subtract per stage
  always_comb begin
    logic [DEN_W-1:0] rem_src;
    logic [Q_W-1:0]   lo_src;
    logic [Q_W-1:0]   q_src;
    logic [DEN_W-1:0] den_src;
    logic [DEN_W:0]   t;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        rem_src = DEN_W'(in_num[NUM_W-1:Q_W]);
        lo_src  = in_num[Q_W-1:0];
        q_src   = '0;
        den_src = in_den;
      end else begin
        rem_src = rem_r[s-1];
        lo_src  = lo_r[s-1];
        q_src   = q_r[s-1];
        den_src = den_r[s-1];
      end
      t = {rem_src, lo_src[Q_W-1]};
      if (t >= {1'b0, den_src}) begin
        rem_nxt[s] = DEN_W'(t - {1'b0, den_src});
        q_nxt[s]   = {q_src[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = t[DEN_W-1:0];
        q_nxt[s]   = {q_src[Q_W-2:0], 1'b0};
      end
      lo_nxt[s] = lo_src << 1;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < Q_W; s++) begin
      rem_r[s]  <= rem_nxt[s];
      lo_r[s]   <= lo_nxt[s];
      q_r[s]    <= q_nxt[s];
      den_r[s]  <= (s == 0) ? in_den : den_r[s-1];
      side_r[s] <= (s == 0) ? in_side : side_r[s-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Q_W-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_q     = q_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

// ===== hw/rtl/spring_edge_force.sv =====
// spring_edge_force: per-edge spring force kernel, Q16.16 fixed point
// depends on sef_pkg, sef_sqrt and sef_div

// The kernel takes one edge in every clock cycle and never stalls: busy stays
// low and cfg_ready stays high. Each edge gives exactly one result, shown for
// one cycle with out_valid high, after the start transfer has passed through
// the 33-stage square root of the squared distance, the 32-stage dividers for
// the velocity and stretch, and eight stages of difference, product and clamp
// logic. Write configuration only while no edge is in flight.
module spring_edge_force
  import sef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_edge_utility,
  input  logic [15:0] in_subject_truth,
  input  logic [15:0] in_predicate_truth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_dv_x,
  output logic [31:0] out_dv_y,
  output logic [31:0] out_dv_z,
  output logic [30:0] out_stretch
);

  cfg_t cfg_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_len       <= REST_DIST_RST;
      cfg_r.repel_len      <= REPEL_DIST_RST;
      cfg_r.min_strength   <= MIN_STR_RST;
      cfg_r.max_strength   <= MAX_STR_RST;
      cfg_r.force_limit    <= FORCE_LIM_RST;
      cfg_r.time_step      <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_REST_DIST:  cfg_r.rest_len       <= cfg_data[30:0];
        REG_REPEL_DIST: cfg_r.repel_len      <= cfg_data[30:0];
        REG_MIN_STR:    cfg_r.min_strength   <= cfg_data[16:0];
        REG_MAX_STR:    cfg_r.max_strength   <= cfg_data[16:0];
        REG_FORCE_LIM:  cfg_r.force_limit    <= cfg_data[30:0];
        REG_TIME_STEP:  cfg_r.time_step      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // stage 1: endpoint differences, utility clamp, edge kind
  logic               s1_vld_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [16:0]        s1_u_r;
  logic               s1_neg_r;
  logic [16:0]        u_clamp;

  always_comb begin
    if (in_edge_utility[31]) begin
      u_clamp = '0;
    end else if (in_edge_utility > 32'd65536) begin
      u_clamp = 17'd65536;
    end else begin
      u_clamp = in_edge_utility[16:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r  <= $signed({in_b_x[31], in_b_x}) - $signed({in_a_x[31], in_a_x});
    s1_dy_r  <= $signed({in_b_y[31], in_b_y}) - $signed({in_a_y[31], in_a_y});
    s1_dz_r  <= $signed({in_b_z[31], in_b_z}) - $signed({in_a_z[31], in_a_z});
    s1_u_r   <= u_clamp;
    s1_neg_r <= !in_subject_truth[15] || !in_predicate_truth[15];
  end

  // stage 2: squares of the differences and of the utility
  logic               s2_vld_r;
  logic [65:0]        s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [16:0]        s2_u2_r;
  logic signed [32:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic               s2_neg_r;
  logic [32:0]        mag_x, mag_y, mag_z;
  logic [33:0]        u_sq;

  assign mag_x = s1_dx_r[32] ? 33'(-s1_dx_r) : 33'(s1_dx_r);
  assign mag_y = s1_dy_r[32] ? 33'(-s1_dy_r) : 33'(s1_dy_r);
  assign mag_z = s1_dz_r[32] ? 33'(-s1_dz_r) : 33'(s1_dz_r);
  assign u_sq  = s1_u_r * s1_u_r;

  always_ff @(posedge clk) begin
    s2_sqx_r <= mag_x * mag_x;
    s2_sqy_r <= mag_y * mag_y;
    s2_sqz_r <= mag_z * mag_z;
    s2_u2_r  <= u_sq[32:16];
    s2_dx_r  <= s1_dx_r;
    s2_dy_r  <= s1_dy_r;
    s2_dz_r  <= s1_dz_r;
    s2_neg_r <= s1_neg_r;
  end

  // stage 3: squared distance and stiffness
  logic               s3_vld_r;
  logic [65:0]        s3_sum_r;
  sqrt_side_t         s3_side_r;
  logic signed [17:0] str_diff;
  logic [16:0]        diff_mag;
  logic [33:0]        k_prod;
  logic signed [18:0] k_full;

  assign str_diff = $signed({1'b0, cfg_r.max_strength}) - $signed({1'b0, cfg_r.min_strength});
  assign diff_mag = str_diff[17] ? 17'(-str_diff) : str_diff[16:0];
  assign k_prod   = s2_u2_r * diff_mag;
  assign k_full   = str_diff[17] ?
                    $signed({2'b00, cfg_r.min_strength}) - $signed({1'b0, k_prod[33:16]}) :
                    $signed({2'b00, cfg_r.min_strength}) + $signed({1'b0, k_prod[33:16]});

  always_ff @(posedge clk) begin
    s3_sum_r      <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
    s3_side_r.d_x <= s2_dx_r;
    s3_side_r.d_y <= s2_dy_r;
    s3_side_r.d_z <= s2_dz_r;
    s3_side_r.k   <= k_full[16:0];
    s3_side_r.neg <= s2_neg_r;
  end

  // distance by square root
  logic        sq_vld;
  logic [32:0] sq_root;
  sqrt_side_t  sq_side;

  sef_sqrt #(
    .RAD_W  (66),
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage E: clamped distance and displacement from equilibrium
  logic               e_vld_r;
  logic [32:0]        e_dist_r, e_absd_r;
  logic               e_dneg_r;
  logic [30:0]        e_eq_r;
  logic [16:0]        e_k_r;
  logic signed [32:0] e_dx_r, e_dy_r, e_dz_r;
  logic [32:0]        dist_c;
  logic [30:0]        eq_c;
  logic signed [33:0] disp_c;

  assign dist_c = (sq_root < ONE_Q) ? ONE_Q : sq_root;
  assign eq_c   = sq_side.neg ? cfg_r.repel_len : cfg_r.rest_len;
  assign disp_c = $signed({1'b0, dist_c}) - $signed({3'b000, eq_c});

  always_ff @(posedge clk) begin
    e_dist_r <= dist_c;
    e_absd_r <= disp_c[33] ? 33'(-disp_c) : disp_c[32:0];
    e_dneg_r <= disp_c[33];
    e_eq_r   <= eq_c;
    e_k_r    <= sq_side.k;
    e_dx_r   <= sq_side.d_x;
    e_dy_r   <= sq_side.d_y;
    e_dz_r   <= sq_side.d_z;
  end

  // stage F: spring force magnitude, clamped to the limit
  logic               f_vld_r;
  logic [30:0]        f_fmag_r;
  logic               f_neg_r;
  logic [32:0]        f_dist_r, f_absd_r;
  logic [30:0]        f_eq_r;
  logic signed [32:0] f_dx_r, f_dy_r, f_dz_r;
  logic [49:0]        force_prod;

  assign force_prod = e_absd_r * e_k_r;

  always_ff @(posedge clk) begin
    f_fmag_r <= (force_prod[49:16] > 34'(cfg_r.force_limit)) ?
                cfg_r.force_limit : force_prod[46:16];
    f_neg_r  <= e_dneg_r;
    f_dist_r <= e_dist_r;
    f_absd_r <= e_absd_r;
    f_eq_r   <= e_eq_r;
    f_dx_r   <= e_dx_r;
    f_dy_r   <= e_dy_r;
    f_dz_r   <= e_dz_r;
  end

  // stage G: scale by the time step
  logic               g_vld_r;
  logic [31:0]        g_fm_r;
  logic               g_neg_r;
  logic [32:0]        g_dist_r, g_absd_r;
  logic [30:0]        g_eq_r;
  logic signed [32:0] g_dx_r, g_dy_r, g_dz_r;
  logic [47:0]        step_prod;

  assign step_prod = f_fmag_r * cfg_r.time_step;

  always_ff @(posedge clk) begin
    g_fm_r   <= step_prod[47:16];
    g_neg_r  <= f_neg_r;
    g_dist_r <= f_dist_r;
    g_absd_r <= f_absd_r;
    g_eq_r   <= f_eq_r;
    g_dx_r   <= f_dx_r;
    g_dy_r   <= f_dy_r;
    g_dz_r   <= f_dz_r;
  end

  // stage H: dividends for velocity and stretch
  logic        h_vld_r;
  logic [63:0] h_px_r, h_py_r, h_pz_r;
  logic        h_sx_r, h_sy_r, h_sz_r;
  logic [32:0] h_dist_r;
  logic [48:0] h_num_r;
  logic [30:0] h_eq_r;
  logic        h_ovf_r;
  logic [32:0] gmag_x, gmag_y, gmag_z;
  logic [64:0] prod_x, prod_y, prod_z;

  assign gmag_x = g_dx_r[32] ? 33'(-g_dx_r) : 33'(g_dx_r);
  assign gmag_y = g_dy_r[32] ? 33'(-g_dy_r) : 33'(g_dy_r);
  assign gmag_z = g_dz_r[32] ? 33'(-g_dz_r) : 33'(g_dz_r);
  assign prod_x = gmag_x * g_fm_r;
  assign prod_y = gmag_y * g_fm_r;
  assign prod_z = gmag_z * g_fm_r;

  always_ff @(posedge clk) begin
    h_px_r   <= prod_x[63:0];
    h_py_r   <= prod_y[63:0];
    h_pz_r   <= prod_z[63:0];
    h_sx_r   <= g_dx_r[32] ^ g_neg_r;
    h_sy_r   <= g_dy_r[32] ^ g_neg_r;
    h_sz_r   <= g_dz_r[32] ^ g_neg_r;
    h_dist_r <= g_dist_r;
    h_num_r  <= {g_absd_r, 16'h0000};
    h_eq_r   <= g_eq_r;
    h_ovf_r  <= (31'(g_absd_r[32:16]) >= g_eq_r);
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      e_vld_r  <= 1'b0;
      f_vld_r  <= 1'b0;
      g_vld_r  <= 1'b0;
      h_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      e_vld_r  <= sq_vld;
      f_vld_r  <= e_vld_r;
      g_vld_r  <= f_vld_r;
      h_vld_r  <= g_vld_r;
    end
  end

  // velocity and stretch dividers
  logic        dv_vld;
  logic [31:0] q_x, q_y, q_z, q_s;
  logic        qs_x, qs_y, qs_z, q_ovf;

  sef_div #(.NUM_W(64), .DEN_W(33), .Q_W(32), .SIDE_W(1)) u_div_x (
    .clk(clk), .rst_n(rst_n), .in_valid(h_vld_r), .in_num(h_px_r), .in_den(h_dist_r),
    .in_side(h_sx_r), .out_valid(dv_vld), .out_q(q_x), .out_side(qs_x)
  );

  sef_div #(.NUM_W(64), .DEN_W(33), .Q_W(32), .SIDE_W(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .in_valid(h_vld_r), .in_num(h_py_r), .in_den(h_dist_r),
    .in_side(h_sy_r), .out_valid(), .out_q(q_y), .out_side(qs_y)
  );

  sef_div #(.NUM_W(64), .DEN_W(33), .Q_W(32), .SIDE_W(1)) u_div_z (
    .clk(clk), .rst_n(rst_n), .in_valid(h_vld_r), .in_num(h_pz_r), .in_den(h_dist_r),
    .in_side(h_sz_r), .out_valid(), .out_q(q_z), .out_side(qs_z)
  );

  sef_div #(.NUM_W(49), .DEN_W(31), .Q_W(32), .SIDE_W(1)) u_div_s (
    .clk(clk), .rst_n(rst_n), .in_valid(h_vld_r), .in_num(h_num_r), .in_den(h_eq_r),
    .in_side(h_ovf_r), .out_valid(), .out_q(q_s), .out_side(q_ovf)
  );

  // signed saturation of a velocity quotient
  function automatic logic [31:0] sat_dv(input logic [31:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = q[31] ? 32'h7FFF_FFFF : q;
    end else if (q > 32'h8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = -q;
    end
    return r;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    out_dv_x    <= sat_dv(q_x, qs_x);
    out_dv_y    <= sat_dv(q_y, qs_y);
    out_dv_z    <= sat_dv(q_z, qs_z);
    out_stretch <= (q_ovf || q_s[31]) ? 31'h7FFF_FFFF : q_s[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld;
    end
  end

  // checks
  a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> ##33 sq_vld)
    else $error("square root lost an item");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r |-> ##33 out_valid)
    else $error("divider lost an item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule
